### design/assert_macros.svh
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property clocked on clk, off while rst_n is low
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be seen
`define ASSERT_NEVER(label, cond, msg) \
    `ASSERT_CLK(label, !(cond), msg)

`endif

### design/bsc_pkg.sv
// Types, constants and helper functions of the bond angle structure classifier
package bsc_pkg;

    localparam int COORD_BITS = 20;
    localparam int MAX_NEIGH  = 32;
    localparam int CUT_W      = 40;

    localparam int IDX_W  = $clog2(MAX_NEIGH);
    localparam int CNT_W  = $clog2(MAX_NEIGH + 1);
    localparam int RSQ_W  = 2 * COORD_BITS;
    localparam int CMP_W  = (RSQ_W > CUT_W) ? RSQ_W : CUT_W;
    localparam int DOT_W  = 2 * COORD_BITS + 1;
    localparam int MAG_W  = 2 * COORD_BITS;
    localparam int SQ_W   = 2 * MAG_W;
    localparam int MEM_W  = 3 * COORD_BITS + RSQ_W;

    localparam int MUL_DIGIT = 8;
    localparam int MUL_STEPS = (MAG_W + MUL_DIGIT - 1) / MUL_DIGIT;
    localparam int MUL_B_W   = MUL_STEPS * MUL_DIGIT;
    localparam int MUL_P_W   = SQ_W + MUL_B_W;
    localparam int MUL_CNT_W = $clog2(MUL_STEPS + 1);

    localparam int SEL_PASSES = 6;
    localparam int PASS_W     = 3;
    localparam int SUM_W      = RSQ_W + 3;
    localparam int SCALE_W    = RSQ_W + 8;
    localparam int SHELL_DEN  = 120;
    localparam int INNER_NUM  = 29;
    localparam int OUTER_NUM  = 31;

    localparam int BIN_N     = 8;
    localparam int BIN_W     = 9;
    localparam int BIN_IDX_W = 3;
    localparam int SHELL_W   = 6;
    localparam int SHELL_LO     = 11;
    localparam int SHELL_CP_HI  = 12;
    localparam int SHELL_ICO_HI = 13;

    localparam int LIM_N     = 9;
    localparam int LIM_W     = 4;
    localparam int LIM_GAP   = 4;
    localparam int LIM_POS   = 5;
    localparam int AP2_W     = 20;
    localparam logic [AP2_W-1:0] MILLI_SQ = AP2_W'(1000000);

    localparam int DEC_W  = 24;
    localparam int CODE_W = 3;

    typedef enum logic [CODE_W-1:0] {
        CODE_NONE = 3'd0,
        CODE_FCC  = 3'd1,
        CODE_BCC  = 3'd2,
        CODE_HCP  = 3'd3,
        CODE_ICO  = 3'd4
    } code_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RSQ,
        ST_STORE,
        ST_SEL,
        ST_INNER,
        ST_PJ,
        ST_PJ_RD,
        ST_PK,
        ST_PK_RD,
        ST_DOT,
        ST_MAG,
        ST_M2,
        ST_P,
        ST_X,
        ST_LIM,
        ST_LIM_WAIT
    } state_t;

    typedef struct packed {
        logic               start;
        logic [SQ_W-1:0]    a;
        logic [MUL_B_W-1:0] b;
    } mul_req_t;

    typedef struct packed {
        logic               done;
        logic [MUL_P_W-1:0] p;
    } mul_rsp_t;

    // squared cosine limit, in millis squared, of each bin boundary
    function automatic logic [AP2_W-1:0] lim_ap2(input logic [LIM_W-1:0] idx);
        logic [AP2_W-1:0] r;
        case (idx)
            4'd0:    r = AP2_W'(893025);
            4'd1:    r = AP2_W'(837225);
            4'd2:    r = AP2_W'(570025);
            4'd3:    r = AP2_W'(497025);
            4'd4:    r = AP2_W'(38025);
            4'd5:    r = AP2_W'(38025);
            4'd6:    r = AP2_W'(60025);
            4'd7:    r = AP2_W'(632025);
            default: r = MILLI_SQ;
        endcase
        return r;
    endfunction

endpackage

### design/bsc_mul.sv
// Iterative unsigned multiplier, one 8-bit digit of the second operand per cycle
module bsc_mul (
    input  logic              clk,
    input  logic              rst_n,
    input  bsc_pkg::mul_req_t req,
    output bsc_pkg::mul_rsp_t rsp
);
    import bsc_pkg::*;

    logic [SQ_W-1:0]           a_reg;
    logic [MUL_B_W-1:0]        b_reg;
    logic [MUL_P_W-1:0]        acc_reg;
    logic [MUL_P_W-1:0]        acc_next;
    logic [MUL_CNT_W-1:0]      cnt_reg;
    logic                      busy_reg;
    logic                      done_reg;
    logic [SQ_W+MUL_DIGIT-1:0] part;

    assign part     = (SQ_W + MUL_DIGIT)'(a_reg)
                    * (SQ_W + MUL_DIGIT)'(b_reg[MUL_B_W-1 -: MUL_DIGIT]);
    assign acc_next = (acc_reg << MUL_DIGIT) + MUL_P_W'(part);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == MUL_CNT_W'(MUL_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            a_reg   <= req.a;
            b_reg   <= req.b;
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            acc_reg <= acc_next;
            b_reg   <= b_reg << MUL_DIGIT;
        end
    end

    assign rsp.done = done_reg;
    assign rsp.p    = acc_reg;

endmodule

### design/bond_angle_structure_classifier.sv
// Top level of the bond angle structure classifier
//
// Use: write the squared cutoff on the cfg channel (cfg_ready is always high)
// while the block is idle. Send one neighbor offset per transfer on the input
// channel (in_valid / in_stall); last_neighbor closes the atom's list and
// starts classification. One result per atom leaves on the output channel
// (out_valid / out_stall) and is held in an output register while stalled.
// A neighbor without last_neighbor passes three squaring steps through the
// single coordinate multiplier, then the cutoff compare and store.
// Classification then reads the 32-entry neighbor memory over one port:
// up to six selection scans plus one shell scan, then for every pair of inner
// neighbors with nonzero distances a run of products through the shared
// digit-serial multiplier (4 to 8 products a pair).
// A new atom is accepted while its predecessor's result waits to be taken.
// Reset clears the cutoff, neighbor count, drop flag, bins and output valid;
// the memory is not cleared and is read only where written for this atom.
module bond_angle_structure_classifier (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [bsc_pkg::CUT_W-1:0]             cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic signed [bsc_pkg::COORD_BITS-1:0] dx,
    input  logic signed [bsc_pkg::COORD_BITS-1:0] dy,
    input  logic signed [bsc_pkg::COORD_BITS-1:0] dz,
    input  logic                                  last_neighbor,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [bsc_pkg::CODE_W-1:0]            structure_code,
    output logic [bsc_pkg::SHELL_W-1:0]           shell_count,
    output logic                                  overflow
);
    import bsc_pkg::*;

    logic [MEM_W-1:0] mem [MAX_NEIGH];
    logic [MEM_W-1:0] mem_q_reg;
    logic             mem_we;
    logic [IDX_W-1:0] mem_wa;
    logic [MEM_W-1:0] mem_wd;
    logic [IDX_W-1:0] rd_addr;

    mul_req_t mul_req;
    mul_rsp_t mul_rsp;

    state_t state_reg, state_next;
    logic [CUT_W-1:0] cutoff_reg, cutoff_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic dropped_reg, dropped_next;
    logic [BIN_W-1:0] bins_reg [BIN_N];
    logic [BIN_W-1:0] bins_next [BIN_N];
    logic out_valid_reg, out_valid_next;

    logic signed [COORD_BITS-1:0] x_reg, x_next, y_reg, y_next, z_reg, z_next;
    logic last_reg, last_next;
    logic [1:0] axis_reg, axis_next;
    logic [RSQ_W-1:0] rsq_reg, rsq_next;
    logic [MAX_NEIGH-1:0] used_reg, used_next, inner_reg, inner_next;
    logic [CNT_W-1:0] scan_reg, scan_next;
    logic rv_reg, rv_next;
    logic [IDX_W-1:0] ridx_reg, ridx_next;
    logic [PASS_W-1:0] pass_reg, pass_next;
    logic [RSQ_W-1:0] best_val_reg, best_val_next;
    logic [IDX_W-1:0] best_idx_reg, best_idx_next;
    logic best_ok_reg, best_ok_next;
    logic [SUM_W-1:0] sum_reg, sum_next;
    logic [SHELL_W-1:0] n1_reg, n1_next;
    logic [CNT_W-1:0] ja_reg, ja_next, kb_reg, kb_next;
    logic signed [COORD_BITS-1:0] ax_reg, ax_next, ay_reg, ay_next, az_reg, az_next;
    logic signed [COORD_BITS-1:0] bx_reg, bx_next, by_reg, by_next, bz_reg, bz_next;
    logic [RSQ_W-1:0] ad_reg, ad_next, bd_reg, bd_next;
    logic signed [DOT_W-1:0] dot_reg, dot_next;
    logic neg_reg, neg_next;
    logic [SQ_W-1:0] m2_reg, m2_next, pp_reg, pp_next;
    logic [MUL_P_W-1:0] xx_reg, xx_next;
    logic [LIM_W-1:0] lim_reg, lim_next;
    code_t code_reg, code_next;
    logic [SHELL_W-1:0] shell_reg, shell_next;
    logic ovf_reg, ovf_next;

    logic signed [COORD_BITS-1:0] op_a, op_b;
    logic signed [2*COORD_BITS-1:0] prod;
    logic signed [COORD_BITS-1:0] q_x, q_y, q_z;
    logic [RSQ_W-1:0] q_d;
    logic signed [DOT_W-1:0] dot_abs;
    logic [SCALE_W-1:0] d_scaled, in_lim, sh_lim;
    code_t dec_code;

    assign cfg_ready      = 1'b1;
    assign in_stall       = (state_reg != ST_IDLE);
    assign out_valid      = out_valid_reg;
    assign structure_code = code_reg;
    assign shell_count    = shell_reg;
    assign overflow       = ovf_reg;

    assign q_x = mem_q_reg[MEM_W-1 -: COORD_BITS];
    assign q_y = mem_q_reg[MEM_W-COORD_BITS-1 -: COORD_BITS];
    assign q_z = mem_q_reg[MEM_W-2*COORD_BITS-1 -: COORD_BITS];
    assign q_d = mem_q_reg[RSQ_W-1:0];

    assign d_scaled = SCALE_W'(q_d) * SCALE_W'(SHELL_DEN);
    assign in_lim   = SCALE_W'(sum_reg) * SCALE_W'(INNER_NUM);
    assign sh_lim   = SCALE_W'(sum_reg) * SCALE_W'(OUTER_NUM);
    assign dot_abs  = dot_reg[DOT_W-1] ? -dot_reg : dot_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        mem_q_reg <= mem[rd_addr];
    end

    bsc_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .rsp   (mul_rsp)
    );

    always_comb
    begin
        case (axis_reg)
            2'd0:    begin op_a = ax_reg; op_b = bx_reg; end
            2'd1:    begin op_a = ay_reg; op_b = by_reg; end
            default: begin op_a = az_reg; op_b = bz_reg; end
        endcase
        if (state_reg == ST_RSQ)
        begin
            case (axis_reg)
                2'd0:    op_a = x_reg;
                2'd1:    op_a = y_reg;
                default: op_a = z_reg;
            endcase
            op_b = op_a;
        end
        prod = op_a * op_b;
    end

    // Ackland rules on the finished bins
    always_comb
    begin
        logic signed [DEC_W-1:0] c [BIN_N];
        logic signed [DEC_W-1:0] den, dev_cp, fa, hb, t0, t1, t2;
        logic bcc_ok;
        logic [SHELL_W-1:0] n1;
        for (int i = 0; i < BIN_N; i++)
        begin
            c[i] = DEC_W'(bins_reg[i]);
        end
        n1     = n1_reg;
        den    = c[5] + c[6] - c[4];
        dev_cp = (c[6] > DEC_W'(24)) ? c[6] - DEC_W'(24) : DEC_W'(24) - c[6];
        if (c[0] == DEC_W'(7) || den < 0)
        begin
            bcc_ok = 1'b1;
        end
        else if (den == 0)
        begin
            bcc_ok = 1'b0;
        end
        else
        begin
            bcc_ok = (DEC_W'(42) * c[4]) <= (DEC_W'(5) * dev_cp * den);
        end
        t0 = c[0] + c[1] - DEC_W'(6);
        t1 = c[0] - DEC_W'(3);
        t2 = c[0] + c[1] + c[2] + c[3] - DEC_W'(9);
        fa = ((t0 < 0) ? -t0 : t0) + c[2];
        hb = ((t1 < 0) ? -t1 : t1) + ((t2 < 0) ? -t2 : t2);
        if (c[0] != DEC_W'(7))
        begin
            if (c[0] == DEC_W'(6))
            begin
                fa = '0;
            end
            else if (c[0] <= DEC_W'(3))
            begin
                hb = '0;
            end
        end
        if (c[7] != 0)
        begin
            dec_code = CODE_NONE;
        end
        else if (c[4] < DEC_W'(3))
        begin
            dec_code = (n1 >= SHELL_W'(SHELL_LO) && n1 <= SHELL_W'(SHELL_ICO_HI))
                     ? CODE_ICO : CODE_NONE;
        end
        else if (bcc_ok)
        begin
            dec_code = (n1 >= SHELL_W'(SHELL_LO)) ? CODE_BCC : CODE_NONE;
        end
        else if (n1 == SHELL_W'(SHELL_LO) || n1 == SHELL_W'(SHELL_CP_HI))
        begin
            dec_code = ((DEC_W'(61) * fa) < (DEC_W'(50) * hb)) ? CODE_FCC : CODE_HCP;
        end
        else
        begin
            dec_code = CODE_NONE;
        end
    end

    always_comb
    begin
        logic out_take;
        logic res_valid, res_hit;
        logic [BIN_IDX_W-1:0] bidx;
        logic [PASS_W-1:0] pass_inc;

        state_next     = state_reg;
        cutoff_next    = cutoff_reg;
        count_next     = count_reg;
        dropped_next   = dropped_reg;
        bins_next      = bins_reg;
        out_valid_next = out_valid_reg;
        x_next = x_reg; y_next = y_reg; z_next = z_reg; last_next = last_reg;
        axis_next = axis_reg; rsq_next = rsq_reg;
        used_next = used_reg; inner_next = inner_reg;
        scan_next = scan_reg; rv_next = rv_reg; ridx_next = ridx_reg;
        pass_next = pass_reg;
        best_val_next = best_val_reg; best_idx_next = best_idx_reg;
        best_ok_next = best_ok_reg;
        sum_next = sum_reg; n1_next = n1_reg;
        ja_next = ja_reg; kb_next = kb_reg;
        ax_next = ax_reg; ay_next = ay_reg; az_next = az_reg; ad_next = ad_reg;
        bx_next = bx_reg; by_next = by_reg; bz_next = bz_reg; bd_next = bd_reg;
        dot_next = dot_reg; neg_next = neg_reg;
        m2_next = m2_reg; pp_next = pp_reg; xx_next = xx_reg; lim_next = lim_reg;
        code_next = code_reg; shell_next = shell_reg; ovf_next = ovf_reg;

        mem_we  = 1'b0;
        mem_wa  = count_reg[IDX_W-1:0];
        mem_wd  = {x_reg, y_reg, z_reg, rsq_reg};
        rd_addr = scan_reg[IDX_W-1:0];
        mul_req = '0;
        res_valid = 1'b0;
        res_hit   = 1'b0;
        pass_inc  = pass_reg + 1'b1;
        bidx      = (lim_reg < LIM_W'(LIM_GAP)) ? BIN_IDX_W'(lim_reg)
                                                : BIN_IDX_W'(lim_reg - 1'b1);

        out_take = out_valid_reg && !out_stall;
        if (out_take)
        begin
            out_valid_next = 1'b0;
        end
        if (cfg_valid)
        begin
            cutoff_next = cfg_data;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    x_next     = dx;
                    y_next     = dy;
                    z_next     = dz;
                    last_next  = last_neighbor;
                    axis_next  = '0;
                    rsq_next   = '0;
                    state_next = ST_RSQ;
                end
            end
            ST_RSQ:
            begin
                rsq_next  = rsq_reg + $unsigned(prod);
                axis_next = axis_reg + 1'b1;
                if (axis_reg == 2'd2)
                begin
                    state_next = ST_STORE;
                end
            end
            ST_STORE:
            begin
                if (CMP_W'(rsq_reg) < CMP_W'(cutoff_reg))
                begin
                    if (count_reg < CNT_W'(MAX_NEIGH))
                    begin
                        mem_we     = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                    else
                    begin
                        dropped_next = 1'b1;
                    end
                end
                if (last_reg)
                begin
                    used_next    = '0;
                    sum_next     = '0;
                    pass_next    = '0;
                    scan_next    = '0;
                    rv_next      = 1'b0;
                    best_ok_next = 1'b0;
                    state_next   = ST_SEL;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SEL:
            begin
                if (scan_reg < count_reg)
                begin
                    scan_next = scan_reg + 1'b1;
                    rv_next   = 1'b1;
                    ridx_next = scan_reg[IDX_W-1:0];
                end
                else
                begin
                    rv_next = 1'b0;
                end
                if (rv_reg && !used_reg[ridx_reg] && (!best_ok_reg || q_d < best_val_reg))
                begin
                    best_ok_next  = 1'b1;
                    best_val_next = q_d;
                    best_idx_next = ridx_reg;
                end
                if (scan_reg == count_reg && !rv_reg)
                begin
                    if (best_ok_reg)
                    begin
                        used_next[best_idx_reg] = 1'b1;
                        sum_next = sum_reg + SUM_W'(best_val_reg);
                    end
                    pass_next    = pass_inc;
                    scan_next    = '0;
                    best_ok_next = 1'b0;
                    if (!(pass_inc < PASS_W'(SEL_PASSES) && CNT_W'(pass_inc) < count_reg))
                    begin
                        inner_next = '0;
                        n1_next    = '0;
                        state_next = ST_INNER;
                    end
                end
            end
            ST_INNER:
            begin
                if (scan_reg < count_reg)
                begin
                    scan_next = scan_reg + 1'b1;
                    rv_next   = 1'b1;
                    ridx_next = scan_reg[IDX_W-1:0];
                end
                else
                begin
                    rv_next = 1'b0;
                end
                if (rv_reg)
                begin
                    inner_next[ridx_reg] = d_scaled < in_lim;
                    if (d_scaled < sh_lim && n1_reg != '1)
                    begin
                        n1_next = n1_reg + 1'b1;
                    end
                end
                if (scan_reg == count_reg && !rv_reg)
                begin
                    for (int i = 0; i < BIN_N; i++)
                    begin
                        bins_next[i] = '0;
                    end
                    ja_next    = '0;
                    state_next = ST_PJ;
                end
            end
            ST_PJ:
            begin
                rd_addr = ja_reg[IDX_W-1:0];
                if (ja_reg >= count_reg)
                begin
                    state_next = ST_LIM_WAIT;
                    if (!out_valid_reg || out_take)
                    begin
                        code_next      = dec_code;
                        shell_next     = n1_reg;
                        ovf_next       = dropped_reg;
                        out_valid_next = 1'b1;
                        count_next     = '0;
                        dropped_next   = 1'b0;
                        state_next     = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_PJ;
                    end
                end
                else if (!inner_reg[ja_reg[IDX_W-1:0]])
                begin
                    ja_next = ja_reg + 1'b1;
                end
                else
                begin
                    state_next = ST_PJ_RD;
                end
            end
            ST_PJ_RD:
            begin
                ax_next    = q_x;
                ay_next    = q_y;
                az_next    = q_z;
                ad_next    = q_d;
                kb_next    = ja_reg + 1'b1;
                state_next = ST_PK;
            end
            ST_PK:
            begin
                rd_addr = kb_reg[IDX_W-1:0];
                if (kb_reg >= count_reg)
                begin
                    ja_next    = ja_reg + 1'b1;
                    state_next = ST_PJ;
                end
                else if (!inner_reg[kb_reg[IDX_W-1:0]])
                begin
                    kb_next = kb_reg + 1'b1;
                end
                else
                begin
                    state_next = ST_PK_RD;
                end
            end
            ST_PK_RD:
            begin
                bx_next = q_x;
                by_next = q_y;
                bz_next = q_z;
                bd_next = q_d;
                if (ad_reg == '0 || q_d == '0)
                begin
                    kb_next    = kb_reg + 1'b1;
                    state_next = ST_PK;
                end
                else
                begin
                    axis_next  = '0;
                    dot_next   = '0;
                    state_next = ST_DOT;
                end
            end
            ST_DOT:
            begin
                dot_next  = dot_reg + DOT_W'(prod);
                axis_next = axis_reg + 1'b1;
                if (axis_reg == 2'd2)
                begin
                    state_next = ST_MAG;
                end
            end
            ST_MAG:
            begin
                neg_next      = dot_reg[DOT_W-1];
                mul_req.start = 1'b1;
                mul_req.a     = SQ_W'(MAG_W'(dot_abs));
                mul_req.b     = MUL_B_W'(MAG_W'(dot_abs));
                state_next    = ST_M2;
            end
            ST_M2:
            begin
                if (mul_rsp.done)
                begin
                    m2_next       = mul_rsp.p[SQ_W-1:0];
                    mul_req.start = 1'b1;
                    mul_req.a     = SQ_W'(ad_reg);
                    mul_req.b     = MUL_B_W'(bd_reg);
                    state_next    = ST_P;
                end
            end
            ST_P:
            begin
                if (mul_rsp.done)
                begin
                    pp_next       = mul_rsp.p[SQ_W-1:0];
                    mul_req.start = 1'b1;
                    mul_req.a     = m2_reg;
                    mul_req.b     = MUL_B_W'(MILLI_SQ);
                    state_next    = ST_X;
                end
            end
            ST_X:
            begin
                if (mul_rsp.done)
                begin
                    xx_next    = mul_rsp.p;
                    lim_next   = '0;
                    state_next = ST_LIM;
                end
            end
            ST_LIM:
            begin
                if (lim_reg >= LIM_W'(LIM_POS) && neg_reg)
                begin
                    res_valid = 1'b1;
                    res_hit   = 1'b1;
                end
                else if (lim_reg < LIM_W'(LIM_POS) && !neg_reg)
                begin
                    res_valid = 1'b1;
                end
                else
                begin
                    mul_req.start = 1'b1;
                    mul_req.a     = pp_reg;
                    mul_req.b     = MUL_B_W'(lim_ap2(lim_reg));
                    state_next    = ST_LIM_WAIT;
                end
            end
            ST_LIM_WAIT:
            begin
                if (mul_rsp.done)
                begin
                    res_valid = 1'b1;
                    res_hit   = neg_reg ? (xx_reg > mul_rsp.p) : (xx_reg < mul_rsp.p);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (res_valid)
        begin
            if (res_hit || lim_reg == LIM_W'(LIM_N - 1))
            begin
                if (res_hit && lim_reg != LIM_W'(LIM_GAP) && bins_reg[bidx] != '1)
                begin
                    bins_next[bidx] = bins_reg[bidx] + 1'b1;
                end
                kb_next    = kb_reg + 1'b1;
                state_next = ST_PK;
            end
            else
            begin
                lim_next   = lim_reg + 1'b1;
                state_next = ST_LIM;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cutoff_reg    <= '0;
            count_reg     <= '0;
            dropped_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < BIN_N; i++)
            begin
                bins_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            cutoff_reg    <= cutoff_next;
            count_reg     <= count_next;
            dropped_reg   <= dropped_next;
            out_valid_reg <= out_valid_next;
            bins_reg      <= bins_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next; y_reg <= y_next; z_reg <= z_next; last_reg <= last_next;
        axis_reg <= axis_next; rsq_reg <= rsq_next;
        used_reg <= used_next; inner_reg <= inner_next;
        scan_reg <= scan_next; rv_reg <= rv_next; ridx_reg <= ridx_next;
        pass_reg <= pass_next;
        best_val_reg <= best_val_next; best_idx_reg <= best_idx_next;
        best_ok_reg <= best_ok_next;
        sum_reg <= sum_next; n1_reg <= n1_next;
        ja_reg <= ja_next; kb_reg <= kb_next;
        ax_reg <= ax_next; ay_reg <= ay_next; az_reg <= az_next; ad_reg <= ad_next;
        bx_reg <= bx_next; by_reg <= by_next; bz_reg <= bz_next; bd_reg <= bd_next;
        dot_reg <= dot_next; neg_reg <= neg_next;
        m2_reg <= m2_next; pp_reg <= pp_next; xx_reg <= xx_next; lim_reg <= lim_next;
        code_reg <= code_next; shell_reg <= shell_next; ovf_reg <= ovf_next;
    end

endmodule

### design/bsc_checker.sv
// Port-level assertions of the bond angle structure classifier, with its bind
`include "assert_macros.svh"

module bsc_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         out_valid,
    input logic                         out_stall,
    input logic [bsc_pkg::CODE_W-1:0]   structure_code,
    input logic [bsc_pkg::SHELL_W-1:0]  shell_count
);
    import bsc_pkg::*;

    `ASSERT_CLK(a_out_hold, out_valid && out_stall |=> out_valid, "result lost while stalled")
    `ASSERT_NEVER(a_code_range, out_valid && structure_code > CODE_ICO, "undefined structure code")
    `ASSERT_NEVER(a_shell_max, out_valid && shell_count > SHELL_W'(MAX_NEIGH), "shell count too high")
    `ASSERT_CLK(a_shell_min, out_valid && structure_code != CODE_NONE |-> shell_count >= SHELL_W'(SHELL_LO), "structure with small shell")
    `ASSERT_CLK(a_close_packed, out_valid && (structure_code == CODE_FCC || structure_code == CODE_HCP) |-> shell_count == SHELL_W'(SHELL_LO) || shell_count == SHELL_W'(SHELL_CP_HI), "close packed outside shell 11 or 12")

endmodule

bind bond_angle_structure_classifier bsc_checker u_bsc_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .structure_code (structure_code),
    .shell_count    (shell_count)
);

### sim/tb_top.sv
// Testbench of the bond angle structure classifier: lattice and noise atoms, checked by a predictor
`timescale 1ns / 1ps

module tb_top;

    import bsc_pkg::*;

    localparam int  ITEMS_PER_PHASE = 175;
    localparam int  CYCLE_LIMIT     = 4000000;
    localparam int  N_RESET_ROWS    = 3;
    localparam int  N_ROWS          = 21;
    localparam int  EDGE_MILLI[10]  = '{-1000, -945, -915, -755, -705, -195, 195, 245, 795, 1000};
    localparam real SQ3             = 1.7320508075688772;
    localparam real PHI             = 1.6180339887498949;

    typedef struct {
        int     x;
        int     y;
        int     z;
        bit     last;
        bit     typed;
        code_t  code;
        int     shell;
        bit     ovf;
    } row_t;

    typedef struct {
        code_t              code;
        logic [SHELL_W-1:0] shell;
        logic               ovf;
    } verdict_t;

    typedef struct {
        int x;
        int y;
        int z;
    } vec_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CUT_W-1:0]      cfg_data;
    logic                  in_valid;
    logic                  in_stall;
    logic [COORD_BITS-1:0] dx;
    logic [COORD_BITS-1:0] dy;
    logic [COORD_BITS-1:0] dz;
    logic                  last_neighbor;
    logic                  out_valid;
    logic                  out_stall;
    logic [CODE_W-1:0]     structure_code;
    logic [SHELL_W-1:0]    shell_count;
    logic                  overflow;

    // classifier state as tracked here
    logic [CUT_W-1:0] cutoff_m;
    longint           nx [MAX_NEIGH];
    longint           ny [MAX_NEIGH];
    longint           nz [MAX_NEIGH];
    longint           rsq_m [MAX_NEIGH];
    int               kept_m;
    bit               dropped_m;

    verdict_t verdicts_q[$];
    vec_t     atom_q[$];
    row_t     rows[N_ROWS];
    int       errors;
    int       items_sent;
    int       atoms_done;
    int       cycles;
    int       stall_left;
    bit       quiet;

    bond_angle_structure_classifier u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .dx             (dx),
        .dy             (dy),
        .dz             (dz),
        .last_neighbor  (last_neighbor),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .structure_code (structure_code),
        .shell_count    (shell_count),
        .overflow       (overflow)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic bit cos_below(longint dot, longint rj, longint rk, int p);
        logic [127:0] lm;
        logic [127:0] a;
        logic [127:0] b;
        logic [127:0] ap;
        bit           neg;
        neg = dot < 0;
        lm  = neg ? 128'(-dot) : 128'(dot);
        lm  = lm * 128'd1000;
        ap  = 128'(p < 0 ? -p : p);
        a   = 128'(rj) * ap;
        b   = 128'(rk) * ap;
        if (p >= 0)
        begin
            if (neg)
                return 1'b1;
            if (p == 0)
                return 1'b0;
            return (lm * lm) < (a * b);
        end
        if (!neg)
            return 1'b0;
        return (lm * lm) > (a * b);
    endfunction

    function automatic code_t classify_atom(output int shell);
        longint ds[$];
        int     inner[$];
        longint sum;
        longint c[8];
        longint den;
        longint dev_cp;
        longint dot;
        longint fa;
        longint hb;
        longint t;
        int     n1;
        int     lo;
        int     a;
        int     b;
        bit     bcc_ok;
        sum = 0;
        n1  = 0;
        for (int i = 0; i < 8; i++)
            c[i] = 0;
        for (int i = 0; i < kept_m; i++)
            ds.push_back(rsq_m[i]);
        ds.sort();
        for (int r = 0; r < 6 && r < kept_m; r++)
            sum += ds[r];
        for (int i = 0; i < kept_m; i++)
        begin
            if (rsq_m[i] * 120 < sum * 29)
                inner.push_back(i);
            if (rsq_m[i] * 120 < sum * 31 && n1 < 63)
                n1++;
        end
        shell = n1;
        for (int j = 0; j + 1 < inner.size(); j++)
        begin
            for (int k = j + 1; k < inner.size(); k++)
            begin
                a = inner[j];
                b = inner[k];
                if (rsq_m[a] == 0 || rsq_m[b] == 0)
                    continue;
                dot = nx[a] * nx[b] + ny[a] * ny[b] + nz[a] * nz[b];
                for (int i = 0; i < 8; i++)
                begin
                    lo = (i < 4) ? i : i + 1;
                    if (!cos_below(dot, rsq_m[a], rsq_m[b], EDGE_MILLI[lo]) &&
                        cos_below(dot, rsq_m[a], rsq_m[b], EDGE_MILLI[lo + 1]))
                    begin
                        if (c[i] < 511)
                            c[i]++;
                        break;
                    end
                end
            end
        end
        if (c[7] != 0)
            return CODE_NONE;
        if (c[4] < 3)
            return (n1 >= SHELL_LO && n1 <= SHELL_ICO_HI) ? CODE_ICO : CODE_NONE;
        den    = c[5] + c[6] - c[4];
        dev_cp = (c[6] > 24) ? c[6] - 24 : 24 - c[6];
        if (c[0] == 7 || den < 0)
            bcc_ok = 1'b1;
        else if (den == 0)
            bcc_ok = 1'b0;
        else
            bcc_ok = 42 * c[4] <= 5 * dev_cp * den;
        if (bcc_ok)
            return (n1 >= SHELL_LO) ? CODE_BCC : CODE_NONE;
        if (n1 == SHELL_LO || n1 == SHELL_CP_HI)
        begin
            t  = c[0] + c[1] - 6;
            fa = ((t < 0) ? -t : t) + c[2];
            t  = c[0] + c[1] + c[2] + c[3] - 9;
            hb = ((c[0] < 3) ? 3 - c[0] : c[0] - 3) + ((t < 0) ? -t : t);
            if (c[0] != 7)
            begin
                if (c[0] == 6)
                    fa = 0;
                else if (c[0] <= 3)
                    hb = 0;
            end
            return (61 * fa < 50 * hb) ? CODE_FCC : CODE_HCP;
        end
        return CODE_NONE;
    endfunction

    // advance the tracked state by one accepted neighbor
    function automatic void absorb(logic [COORD_BITS-1:0] vx, logic [COORD_BITS-1:0] vy,
                                   logic [COORD_BITS-1:0] vz, bit last, bit typed,
                                   verdict_t typed_v);
        longint   x;
        longint   y;
        longint   z;
        longint   r;
        int       sh;
        verdict_t v;
        x = longint'($signed(vx));
        y = longint'($signed(vy));
        z = longint'($signed(vz));
        r = x * x + y * y + z * z;
        if (r < longint'(cutoff_m))
        begin
            if (kept_m < MAX_NEIGH)
            begin
                nx[kept_m]    = x;
                ny[kept_m]    = y;
                nz[kept_m]    = z;
                rsq_m[kept_m] = r;
                kept_m++;
            end
            else
                dropped_m = 1'b1;
        end
        if (!last)
            return;
        v.code  = classify_atom(sh);
        v.shell = SHELL_W'(sh);
        v.ovf   = dropped_m;
        verdicts_q.push_back(typed ? typed_v : v);
        kept_m    = 0;
        dropped_m = 1'b0;
        atoms_done++;
    endfunction

    task automatic send(int x, int y, int z, bit last, bit typed, verdict_t typed_v);
        int gap;
        gap = pick_gap();
        repeat (gap)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        dx            <= COORD_BITS'(x);
        dy            <= COORD_BITS'(y);
        dz            <= COORD_BITS'(z);
        last_neighbor <= last;
        do
            @(posedge clk);
        while (in_stall);
        absorb(COORD_BITS'(x), COORD_BITS'(y), COORD_BITS'(z), last, typed, typed_v);
        items_sent++;
    endtask

    task automatic write_cutoff(logic [CUT_W-1:0] value);
        in_valid <= 1'b0;
        while (verdicts_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        cutoff_m  = value;
    endtask

    task automatic add_vec(real vx, real vy, real vz, real s, int j);
        vec_t v;
        v.x = int'(vx * s) + $urandom_range(0, 2 * j) - j;
        v.y = int'(vy * s) + $urandom_range(0, 2 * j) - j;
        v.z = int'(vz * s) + $urandom_range(0, 2 * j) - j;
        atom_q.push_back(v);
    endtask

    // build one atom's neighbor list: lattice shells with jitter, or noise
    task automatic build_atom();
        int  kind;
        int  n;
        int  j;
        int  m;
        real s;
        real ang;
        real d;
        vec_t v;
        atom_q.delete();
        kind = $urandom_range(0, 9);
        s    = real'($urandom_range(1500, 9000));
        j    = $urandom_range(0, 1) ? 0 : $urandom_range(0, int'(s / 40.0));
        case (kind)
            0, 1, 2, 3:
            begin
                for (int k = 0; k < 6; k++)
                begin
                    ang = k * 3.14159265358979 / 3.0;
                    add_vec($cos(ang), $sin(ang), 0.0, s, j);
                end
                for (int k = 0; k < 3; k++)
                begin
                    ang = (30.0 + 120.0 * k) * 3.14159265358979 / 180.0;
                    add_vec($cos(ang) / SQ3, $sin(ang) / SQ3, 0.816496580927726, s, j);
                    if (kind < 2)
                        ang = (90.0 + 120.0 * k) * 3.14159265358979 / 180.0;
                    add_vec($cos(ang) / SQ3, $sin(ang) / SQ3, -0.816496580927726, s, j);
                end
            end
            4, 5:
            begin
                for (int k = 0; k < 8; k++)
                    add_vec((k & 1) ? 1.0 / SQ3 : -1.0 / SQ3, (k & 2) ? 1.0 / SQ3 : -1.0 / SQ3,
                            (k & 4) ? 1.0 / SQ3 : -1.0 / SQ3, s, j);
                for (int k = 0; k < 6; k++)
                    add_vec((k / 2 == 0) ? ((k & 1) ? 2.0 / SQ3 : -2.0 / SQ3) : 0.0,
                            (k / 2 == 1) ? ((k & 1) ? 2.0 / SQ3 : -2.0 / SQ3) : 0.0,
                            (k / 2 == 2) ? ((k & 1) ? 2.0 / SQ3 : -2.0 / SQ3) : 0.0, s, j);
            end
            6, 7:
            begin
                d = $sqrt(1.0 + PHI * PHI);
                for (int k = 0; k < 12; k++)
                begin
                    if (k / 4 == 0)
                        add_vec(0.0, ((k & 1) ? 1.0 : -1.0) / d, ((k & 2) ? PHI : -PHI) / d, s, j);
                    else if (k / 4 == 1)
                        add_vec(((k & 1) ? 1.0 : -1.0) / d, ((k & 2) ? PHI : -PHI) / d, 0.0, s, j);
                    else
                        add_vec(((k & 2) ? PHI : -PHI) / d, 0.0, ((k & 1) ? 1.0 : -1.0) / d, s, j);
                end
            end
            default:
            begin
                n = ($urandom_range(0, 11) == 0) ? $urandom_range(33, 36) : $urandom_range(1, 14);
                for (int k = 0; k < n; k++)
                begin
                    if ($urandom_range(0, 2) == 0)
                    begin
                        v.x = int'($urandom());
                        v.y = int'($urandom());
                        v.z = int'($urandom());
                    end
                    else
                    begin
                        m   = $urandom_range(0, 12000);
                        v.x = $urandom_range(0, 2 * m) - m;
                        v.y = $urandom_range(0, 2 * m) - m;
                        v.z = $urandom_range(0, 2 * m) - m;
                    end
                    atom_q.push_back(v);
                end
            end
        endcase
        if (kind < 8)
        begin
            m = $urandom_range(0, 4);
            repeat (m)
                add_vec(real'($urandom_range(0, 40)) / 10.0 - 2.0, real'($urandom_range(0, 40)) / 10.0 - 2.0,
                        2.0, s, j);
            if ($urandom_range(0, 7) == 0)
                atom_q.delete($urandom_range(0, atom_q.size() - 1));
        end
        atom_q.shuffle();
    endtask

    task automatic run_phase(logic [CUT_W-1:0] cutoff, bit calm);
        verdict_t none_v;
        none_v = '{CODE_NONE, '0, 1'b0};
        write_cutoff(cutoff);
        quiet = calm;
        for (int target = items_sent + ITEMS_PER_PHASE; items_sent < target; )
        begin
            build_atom();
            for (int k = 0; k < atom_q.size(); k++)
                send(atom_q[k].x, atom_q[k].y, atom_q[k].z, k == atom_q.size() - 1, 1'b0, none_v);
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left > 0)
            stall_left <= stall_left - 1;
        else
        begin
            stall_left <= pick_gap();
            out_stall  <= !quiet && $urandom_range(0, 3) == 0;
        end
    end

    always @(posedge clk)
    begin
        verdict_t v;
        if (rst_n && out_valid && !out_stall)
        begin
            if (verdicts_q.size() == 0)
            begin
                $error("result transfer with nothing expected");
                errors++;
            end
            else
            begin
                v = verdicts_q.pop_front();
                if (structure_code !== v.code)
                begin
                    $error("structure_code: expected %0d, got %0d", v.code, structure_code);
                    errors++;
                end
                if (shell_count !== v.shell)
                begin
                    $error("shell_count: expected %0d, got %0d", v.shell, shell_count);
                    errors++;
                end
                if (overflow !== v.ovf)
                begin
                    $error("overflow: expected %0d, got %0d", v.ovf, overflow);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("** bond_angle_structure_classifier: FAILED **");
            $finish;
        end
    end

    initial
    begin
        verdict_t tv;
        errors     = 0;
        items_sent = 0;
        atoms_done = 0;
        cycles     = 0;
        quiet      = 1'b0;
        cutoff_m   = '0;
        kept_m     = 0;
        dropped_m  = 1'b0;
        rst_n         <= 1'b0;
        cfg_valid     <= 1'b0;
        cfg_data      <= '0;
        in_valid      <= 1'b0;
        dx            <= '0;
        dy            <= '0;
        dz            <= '0;
        last_neighbor <= 1'b0;

        // cutoff zero after reset keeps nothing; then all-ones cutoff
        rows = '{
            '{0, 0, 0, 1, 1, CODE_NONE, 0, 0},
            '{-524288, -524288, -524288, 1, 1, CODE_NONE, 0, 0},
            '{524287, 524287, 524287, 1, 1, CODE_NONE, 0, 0},
            '{0, 0, 0, 1, 1, CODE_NONE, 0, 0},
            '{-524288, -524288, -524288, 0, 0, CODE_NONE, 0, 0},
            '{524287, 524287, 524287, 0, 0, CODE_NONE, 0, 0},
            '{0, 0, 0, 0, 0, CODE_NONE, 0, 0},
            '{1, -1, 0, 1, 0, CODE_NONE, 0, 0},
            '{4096, 4096, 0, 0, 0, CODE_NONE, 0, 0},
            '{4096, -4096, 0, 0, 0, CODE_NONE, 0, 0},
            '{-4096, 4096, 0, 0, 0, CODE_NONE, 0, 0},
            '{-4096, -4096, 0, 0, 0, CODE_NONE, 0, 0},
            '{4096, 0, 4096, 0, 0, CODE_NONE, 0, 0},
            '{4096, 0, -4096, 0, 0, CODE_NONE, 0, 0},
            '{-4096, 0, 4096, 0, 0, CODE_NONE, 0, 0},
            '{-4096, 0, -4096, 0, 0, CODE_NONE, 0, 0},
            '{0, 4096, 4096, 0, 0, CODE_NONE, 0, 0},
            '{0, 4096, -4096, 0, 0, CODE_NONE, 0, 0},
            '{0, -4096, 4096, 0, 0, CODE_NONE, 0, 0},
            '{0, -4096, -4096, 0, 0, CODE_NONE, 0, 0},
            '{300000, -200000, 100000, 1, 0, CODE_NONE, 0, 0}
        };

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < N_ROWS; r++)
        begin
            if (r == N_RESET_ROWS)
                write_cutoff({CUT_W{1'b1}});
            tv = '{rows[r].code, SHELL_W'(rows[r].shell), rows[r].ovf};
            send(rows[r].x, rows[r].y, rows[r].z, rows[r].last, rows[r].typed, tv);
        end

        run_phase({CUT_W{1'b1}}, 1'b0);
        run_phase({8'($urandom()), 32'($urandom())}, 1'b1);
        run_phase(CUT_W'(64'd150000000), 1'b0);
        run_phase('0, 1'b0);
        run_phase({CUT_W{1'b1}}, 1'b0);

        in_valid <= 1'b0;
        while (verdicts_q.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);

        $display("covered %0d neighbor transfers in %0d atoms over 6 cutoff settings",
                 items_sent, atoms_done);
        $display("lattice shells (fcc, hcp, bcc, icosahedral), noise and store overflow atoms");
        if (errors == 0)
            $display("** bond_angle_structure_classifier: PASSED **");
        else
            $display("** bond_angle_structure_classifier: FAILED **");
        $finish;
    end

endmodule
